/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the date converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge, muted while rst_n is low.
`define PDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising clk edge, reset included.
`define PDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pgdc_pkg.sv */
// ----------------------------------------------------------------------------
// pgdc_pkg
// Types, constants and calendar tables of the Gregorian/Persian date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pgdc_pkg;

    localparam int TDATA_W  = 24;
    localparam int YEAR_W   = 14;
    localparam int GYEAR_W  = 15;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DOY_W    = 9;
    localparam int ORD_W    = 10;
    localparam int QUO_W    = 10;
    localparam int PROD_W   = 31;

    localparam logic [MONTH_W-1:0] N_MONTHS   = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEY  = 4'd10;

    // Calendar offsets
    localparam logic [GYEAR_W-1:0] YEAR_SHIFT    = 15'd621;
    localparam logic [ORD_W-1:0]   NOWRUZ_DOY    = 10'd79;
    localparam logic [ORD_W-1:0]   PERS_JAN_DOY  = 10'd286;
    localparam int                 PERS_OFFSET   = 474;
    localparam int                 PERS_CYCLE    = 128;
    localparam logic [6:0]         PERS_OFS7     = 7'(PERS_OFFSET % PERS_CYCLE);
    localparam logic [6:0]         PERS_WRAP_LIM = 7'd30;
    localparam logic [6:0]         PERS_WRAP_ADD = 7'd29;
    localparam logic [6:0]         PERS_SUB_DIV  = 7'd33;

    // Divide by 25 through a reciprocal; exact for every 15-bit year
    localparam int                 DIV25         = 25;
    localparam int                 DIV25_SHIFT   = 20;
    localparam logic [15:0]        DIV25_RECIP   = 16'(((1 << DIV25_SHIFT) + DIV25 - 1) / DIV25);

    localparam logic [DOY_W-1:0] GREG_CUM [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [DOY_W-1:0] PERS_CUM [13] = '{
        9'd0, 9'd31, 9'd62, 9'd93, 9'd124, 9'd155, 9'd186,
        9'd216, 9'd246, 9'd276, 9'd306, 9'd336, 9'd365
    };

    typedef struct packed {
        logic                func;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } st1_t;

    typedef struct packed {
        logic                func;
        logic [GYEAR_W-1:0]  gyear;
        logic [YEAR_W-1:0]   oyear;
        logic [DOY_W-1:0]    doy;
        logic                mok;
        logic                m_gt2;
        logic                m_eq10;
        logic                m_gt10;
        logic                pl_cur;
        logic                pl_prev;
    } st2_t;

    typedef struct packed {
        st2_t                core;
        logic [QUO_W-1:0]    quo;
    } st3_t;

    typedef struct packed {
        logic                func;
        logic [YEAR_W-1:0]   oyear;
        logic [DOY_W-1:0]    doy;
        logic                mok;
        logic                m_gt2;
        logic                m_eq10;
        logic                m_gt10;
        logic                pl_cur;
        logic                pl_prev;
        logic                gl_prev;
        logic                gl_cur;
        logic                gl_next;
    } st4_t;

    typedef struct packed {
        logic                gcal;
        logic                leap;
        logic [ORD_W-1:0]    ord;
        logic [YEAR_W-1:0]   oyear;
        logic                mok;
    } st5_t;

    typedef struct packed {
        logic                bad;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } place_t;

    // Cumulative days before month idx+1 (idx 12 = year length)
    function automatic logic [DOY_W-1:0] cum_val(input logic gcal, input logic leap,
                                                 input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] v;
        v = '0;
        if (idx <= N_MONTHS) begin
            if (gcal) begin
                v = GREG_CUM[idx] + DOY_W'(leap && (idx >= MONTH_FEB));
            end
            else begin
                v = PERS_CUM[idx] + DOY_W'(leap && (idx == N_MONTHS));
            end
        end
        return v;
    endfunction

    // Persian leap test; only the low 7 bits of the year matter
    function automatic logic pers_leap7(input logic [6:0] yl);
        logic [6:0] t;
        logic [1:0] q;
        logic [6:0] u;
        t = yl - PERS_OFS7;
        if (t < PERS_WRAP_LIM) begin
            t = t + PERS_WRAP_ADD;
        end
        priority if (t >= 7'(3 * PERS_SUB_DIV)) q = 2'd3;
        else if (t >= 7'(2 * PERS_SUB_DIV))     q = 2'd2;
        else if (t >= PERS_SUB_DIV)             q = 2'd1;
        else                                    q = 2'd0;
        u = t - {5'b0, q} - 7'd1;
        return (u[1:0] == 2'b00);
    endfunction

endpackage

`default_nettype wire

/* sv/pgdc_month_find.sv */
// ----------------------------------------------------------------------------
// pgdc_month_find
// Month and day of month for a day of year, with range check.
// ----------------------------------------------------------------------------
`default_nettype none

module pgdc_month_find (
    input  wire logic [pgdc_pkg::ORD_W-1:0] ord,
    input  wire logic                       gcal,
    input  wire logic                       leap,
    output pgdc_pkg::place_t                res
);
    import pgdc_pkg::*;

    logic [MONTH_W-1:0] month;
    logic [DOY_W-1:0]   prev_cum;
    logic [ORD_W-1:0]   day_full;

    // Pick the first month whose running total reaches the day of year
    always_comb
    begin
        month = '0;
        for (int i = 12; i >= 1; i--)
        begin
            if (ord <= {1'b0, cum_val(gcal, leap, MONTH_W'(i))}) begin
                month = MONTH_W'(i);
            end
        end
    end

    assign prev_cum  = cum_val(gcal, leap, month - MONTH_W'(1));
    assign day_full  = ord - {1'b0, prev_cum};
    assign res.bad   = (ord == '0) || (month == '0);
    assign res.month = month;
    assign res.day   = day_full[DAY_W-1:0];

endmodule

`default_nettype wire

/* sv/persian_gregorian_date_converter.sv */
// ----------------------------------------------------------------------------
// persian_gregorian_date_converter
// Pipelined Gregorian <-> Persian (solar Hijri) date converter.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* takes one conversion request per word: tuser selects
//   the direction (0 = Gregorian to Persian, 1 = Persian to Gregorian) and
//   tdata carries year, month and day. Master channel m_* returns one word
//   per request, in order: tdata holds the target year, month and day,
//   tuser flags a bad month or a date that fits no month (payload then reads zero).
// Throughput: one word per cycle while m_tready stays high; five register
//   stages plus the output register, with the divide-by-25 for the Gregorian
//   leap rule spread over a multiply stage and a remainder stage.
// Stalls: each stage holds while the one after it is full and stalled;
//   s_tready drops only when every stage up to the output holds a word, so
//   bubbles are squeezed out while m_tready is low. Nothing is lost or
//   repeated.
// Reset: rst_n clears every valid bit; the pipeline comes out empty and
//   ready. The block keeps no state between words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module persian_gregorian_date_converter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [pgdc_pkg::TDATA_W-1:0] s_tdata,   // in_year, in_month, in_day, pad
    input  wire logic                         s_tuser,   // func
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [pgdc_pkg::TDATA_W-1:0]      m_tdata,   // out_year, out_month, out_day, pad
    output logic                              m_tuser    // bad_date
);
    import pgdc_pkg::*;

    // Stage valid bits and payload registers
    logic st1_v_reg, st2_v_reg, st3_v_reg, st4_v_reg, st5_v_reg, out_v_reg;
    st1_t st1_reg;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st5_t st5_reg, st5_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic               out_bad_reg, out_bad_next;

    // A stage loads when it is empty or its contents move on
    logic en1, en2, en3, en4, en5, en_out;

    assign en_out   = !out_v_reg || m_tready;
    assign en5      = !st5_v_reg || en_out;
    assign en4      = !st4_v_reg || en5;
    assign en3      = !st3_v_reg || en4;
    assign en2      = !st2_v_reg || en3;
    assign en1      = !st1_v_reg || en2;
    assign s_tready = en1;

    // ---------------- stage 2: table lookup, year bases, Persian leap bits
    logic [MONTH_W-1:0] m_idx;
    logic [6:0]         pers_base;

    always_comb
    begin
        m_idx          = st1_reg.month - MONTH_W'(1);
        st2_next.func  = st1_reg.func;
        st2_next.mok   = (st1_reg.month != '0) && (st1_reg.month <= N_MONTHS);
        // Look up the source calendar; Persian months 1..12 start at the same
        // offset in both year kinds, the Gregorian leap day is added later
        st2_next.doy   = cum_val(!st1_reg.func, 1'b0, m_idx) + DOY_W'(st1_reg.day);
        st2_next.m_gt2  = st1_reg.month > MONTH_FEB;
        st2_next.m_eq10 = st1_reg.month == MONTH_DEY;
        st2_next.m_gt10 = st1_reg.month > MONTH_DEY;
        if (st1_reg.func) begin
            st2_next.gyear = {1'b0, st1_reg.year} + YEAR_SHIFT;
            st2_next.oyear = st1_reg.year + YEAR_SHIFT[YEAR_W-1:0];
            pers_base      = st1_reg.year[6:0];
        end
        else begin
            st2_next.gyear = {1'b0, st1_reg.year};
            st2_next.oyear = st1_reg.year - YEAR_SHIFT[YEAR_W-1:0];
            pers_base      = st1_reg.year[6:0] - YEAR_SHIFT[6:0];
        end
        st2_next.pl_cur  = pers_leap7(pers_base);
        st2_next.pl_prev = pers_leap7(pers_base - 7'd1);
    end

    // ---------------- stage 3: quotient of Gregorian year by 25
    logic [PROD_W-1:0] prod;

    assign prod          = PROD_W'(st2_reg.gyear) * PROD_W'(DIV25_RECIP);
    assign st3_next.core = st2_reg;
    assign st3_next.quo  = QUO_W'(prod >> DIV25_SHIFT);

    // ---------------- stage 4: remainder and Gregorian leap of year-1, year, year+1
    logic [GYEAR_W-1:0] q25;
    logic [4:0]         rem;
    logic [3:0]         g_lo, g_lo_p1, g_lo_m1;

    always_comb
    begin
        q25     = GYEAR_W'(st3_reg.quo) * GYEAR_W'(DIV25);
        rem     = 5'(st3_reg.core.gyear - q25);
        g_lo    = st3_reg.core.gyear[3:0];
        g_lo_p1 = g_lo + 4'd1;
        g_lo_m1 = g_lo - 4'd1;

        st4_next.func    = st3_reg.core.func;
        st4_next.oyear   = st3_reg.core.oyear;
        st4_next.doy     = st3_reg.core.doy;
        st4_next.mok     = st3_reg.core.mok;
        st4_next.m_gt2   = st3_reg.core.m_gt2;
        st4_next.m_eq10  = st3_reg.core.m_eq10;
        st4_next.m_gt10  = st3_reg.core.m_gt10;
        st4_next.pl_cur  = st3_reg.core.pl_cur;
        st4_next.pl_prev = st3_reg.core.pl_prev;
        // Leap: divisible by 4, and not a century unless divisible by 400
        st4_next.gl_cur  = (g_lo[1:0] == 2'b00)
                           && !((rem == 5'd0) && (g_lo != 4'd0));
        st4_next.gl_next = (g_lo_p1[1:0] == 2'b00)
                           && !((rem == 5'(DIV25 - 1)) && (g_lo_p1 != 4'd0));
        st4_next.gl_prev = (g_lo_m1[1:0] == 2'b00)
                           && !((rem == 5'd1) && (g_lo_m1 != 4'd0));
    end

    // ---------------- stage 5: cross the new-year boundary
    logic [ORD_W-1:0] doy_ext, ge, nr, lim;

    always_comb
    begin
        doy_ext       = {1'b0, st4_reg.doy};
        ge            = doy_ext + ORD_W'(st4_reg.gl_cur && st4_reg.m_gt2);
        nr            = NOWRUZ_DOY + ORD_W'(st4_reg.pl_prev && st4_reg.gl_cur);
        lim           = PERS_JAN_DOY + ORD_W'(st4_reg.gl_cur);
        st5_next.gcal = st4_reg.func;
        st5_next.mok  = st4_reg.mok;
        if (!st4_reg.func) begin
            if (ge <= nr) begin
                // Before Nowruz: day falls in the previous Persian year
                st5_next.ord   = ge + PERS_JAN_DOY
                                 + ORD_W'(st4_reg.pl_prev && !st4_reg.gl_cur);
                st5_next.oyear = st4_reg.oyear - YEAR_W'(1);
                st5_next.leap  = st4_reg.pl_prev;
            end
            else begin
                st5_next.ord   = ge - nr;
                st5_next.oyear = st4_reg.oyear;
                st5_next.leap  = st4_reg.pl_cur;
            end
        end
        else begin
            if (st4_reg.m_gt10 || (st4_reg.m_eq10 && (doy_ext > lim))) begin
                // On or after January 1: day falls in the next Gregorian year
                st5_next.ord   = doy_ext - lim;
                st5_next.oyear = st4_reg.oyear + YEAR_W'(1);
                st5_next.leap  = st4_reg.gl_next;
            end
            else begin
                st5_next.ord   = doy_ext + NOWRUZ_DOY + ORD_W'(st4_reg.pl_prev)
                                 - ORD_W'(st4_reg.gl_prev);
                st5_next.oyear = st4_reg.oyear;
                st5_next.leap  = st4_reg.gl_cur;
            end
        end
    end

    // ---------------- output stage: month and day
    place_t place;

    pgdc_month_find u_month_find (
        .ord  (st5_reg.ord),
        .gcal (st5_reg.gcal),
        .leap (st5_reg.leap),
        .res  (place)
    );

    always_comb
    begin
        if (place.bad || !st5_reg.mok) begin
            out_bad_next  = 1'b1;
            out_data_next = '0;
        end
        else begin
            out_bad_next  = 1'b0;
            out_data_next = {1'b0, place.day, place.month, st5_reg.oyear};
        end
    end

    // ---------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
            st4_v_reg <= 1'b0;
            st5_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else begin
            if (en1)    st1_v_reg <= s_tvalid;
            if (en2)    st2_v_reg <= st1_v_reg;
            if (en3)    st3_v_reg <= st2_v_reg;
            if (en4)    st4_v_reg <= st3_v_reg;
            if (en5)    st5_v_reg <= st4_v_reg;
            if (en_out) out_v_reg <= st5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) begin
            st1_reg.func  <= s_tuser;
            st1_reg.year  <= s_tdata[YEAR_W-1:0];
            st1_reg.month <= s_tdata[YEAR_W+MONTH_W-1:YEAR_W];
            st1_reg.day   <= s_tdata[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W];
        end
        if (en2)    st2_reg <= st2_next;
        if (en3)    st3_reg <= st3_next;
        if (en4)    st4_reg <= st4_next;
        if (en5)    st5_reg <= st5_next;
        if (en_out) begin
            out_data_reg <= out_data_next;
            out_bad_reg  <= out_bad_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

    // ---------------- assertions
    `PDC_ASSERT(a_bad_zero, m_tvalid && m_tuser |-> m_tdata == '0, "flagged word carries data")
    `PDC_ASSERT(a_month_range, m_tvalid && !m_tuser |-> (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= N_MONTHS), "month out of range")
    `PDC_ASSERT(a_day_nonzero, m_tvalid && !m_tuser |-> m_tdata[22:18] != 5'd0, "day of month is zero")
    `PDC_ASSERT(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
    `PDC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !m_tvalid, "output valid right after reset")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian/Persian date converter. Each request
// word is converted by a behavioral calendar model inside the bench at the
// moment it is accepted, and the results come back in order. Both stream
// sides idle and stall at random, with stretches of full-rate traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pgdc_pkg::*;

    // Direction select carried on s_tuser
    localparam logic DIR_G2P = 1'b0;    // Gregorian to Persian
    localparam logic DIR_P2G = 1'b1;    // Persian to Gregorian

    localparam int N_RANDOM    = 1750;
    localparam int MAX_WAIT    = 13;
    localparam int DRAIN_EDGES = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // Days before month i+1; index 12 is the length of a common year
    localparam int GREG_DAYS_BEFORE [0:12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };
    localparam int PERS_DAYS_BEFORE [0:12] = '{
        0, 31, 62, 93, 124, 155, 186, 216, 246, 276, 306, 336, 365
    };

    typedef struct packed {
        logic               dir;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               bad;
    } date_res_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;   // in_year, in_month, in_day, pad
    logic                s_tuser  = 1'b0; // func
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;         // out_year, out_month, out_day, pad
    logic                m_tuser;         // bad_date

    date_req_t pending_dates [$];
    date_res_t converted_dates [$];

    int  mismatches    = 0;
    int  cycles        = 0;
    int  sent_g2p      = 0;
    int  sent_p2g      = 0;
    int  seen_bad      = 0;
    int  seen_words    = 0;
    int  send_wait     = 0;
    int  recv_wait     = 0;
    bit  send_burst    = 1'b0;
    bit  recv_burst    = 1'b0;

    persian_gregorian_date_converter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------
    function automatic int greg_leap(input int y);
        return (y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) ? 1 : 0;
    endfunction

    // 128-year cycle rule, floor modulo on the year offset
    function automatic int pers_leap(input int y);
        int t;
        t = (y - 474) % 128;
        if (t < 0)
            t += 128;
        if (t < 30)
            t += 29;
        t = t - t / 33 - 1;
        return (t % 4 == 0) ? 1 : 0;
    endfunction

    // Cumulative days through month idx; the leap day sits in Feb or Esfand
    function automatic int days_through(input bit gcal, input int leap, input int idx);
        if (gcal)
            return GREG_DAYS_BEFORE[idx] + ((leap != 0 && idx >= 2) ? 1 : 0);
        return PERS_DAYS_BEFORE[idx] + ((leap != 0 && idx == 12) ? 1 : 0);
    endfunction

    // Turn a day of year into month/day; flag it when no month holds it
    function automatic date_res_t place_day(input bit gcal, input int leap, input int doy,
                                            input int yr);
        date_res_t r;
        r = '{year: '0, month: '0, day: '0, bad: 1'b1};
        if (doy >= 1) begin
            for (int i = 1; i <= 12; i++) begin
                if (r.bad && days_through(gcal, leap, i) >= doy) begin
                    r.year  = YEAR_W'(yr);
                    r.month = MONTH_W'(i);
                    r.day   = DAY_W'(doy - days_through(gcal, leap, i - 1));
                    r.bad   = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic date_res_t convert_date(input date_req_t q);
        date_res_t r;
        int y, m, d, py, gy, gl, pl, ge, pe, nr;
        y = int'(q.year);
        m = int'(q.month);
        d = int'(q.day);
        r = '{year: '0, month: '0, day: '0, bad: 1'b1};
        if (m < 1 || m > 12)
            return r;
        if (q.dir == DIR_G2P) begin
            py = y - 621;
            gl = greg_leap(y);
            pl = pers_leap(py - 1);
            ge = days_through(1'b1, gl, m - 1) + d;
            nr = (pl != 0 && gl != 0) ? 80 : 79;
            // Before Nowruz the date still belongs to the previous Persian year
            if (ge <= nr) begin
                pe = ge + 286;
                py--;
                if (pl != 0 && gl == 0)
                    pe++;
            end
            else begin
                pe = ge - nr;
                pl = pers_leap(py);
            end
            r = place_day(1'b0, pl, pe, py);
        end
        else begin
            gy = y + 621;
            pl = pers_leap(y);
            gl = greg_leap(gy);
            pe = days_through(1'b0, pl, m - 1) + d;
            // Past 10 Dey the date falls into the next Gregorian year
            if (m > 10 || (m == 10 && pe > 286 + gl)) begin
                ge = pe - (286 + gl);
                gy++;
                gl = greg_leap(gy);
            end
            else begin
                ge = pe + 79 + pers_leap(y - 1) - greg_leap(gy - 1);
            end
            r = place_day(1'b1, gl, ge, gy);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    function automatic date_req_t make_date(input logic dir, input int y, input int m,
                                            input int d);
        date_req_t q;
        q.dir   = dir;
        q.year  = YEAR_W'(y);
        q.month = MONTH_W'(m);
        q.day   = DAY_W'(d);
        return q;
    endfunction

    // Mostly plausible dates, weighted toward the new-year seams, with some
    // out-of-range years, months and days mixed in.
    function automatic date_req_t random_date();
        date_req_t q;
        int pick;
        q.dir  = logic'($urandom_range(0, 1));
        q.year = ($urandom_range(0, 31) == 0) ? YEAR_W'($urandom_range(0, 16383))
                                              : YEAR_W'($urandom_range(1, 9999));
        pick = $urandom_range(0, 15);
        if (pick < 3) begin
            // Near the calendar seams: Nowruz, Dey 10/11, year ends
            if (q.dir == DIR_G2P) begin
                case ($urandom_range(0, 2))
                    0:       begin q.month = 4'd3;  q.day = DAY_W'($urandom_range(18, 23)); end
                    1:       begin q.month = 4'd1;  q.day = DAY_W'($urandom_range(0, 2));   end
                    default: begin q.month = 4'd12; q.day = DAY_W'($urandom_range(29, 31)); end
                endcase
            end
            else begin
                case ($urandom_range(0, 2))
                    0:       begin q.month = 4'd10; q.day = DAY_W'($urandom_range(8, 13));  end
                    1:       begin q.month = 4'd1;  q.day = DAY_W'($urandom_range(0, 2));   end
                    default: begin q.month = 4'd12; q.day = DAY_W'($urandom_range(28, 31)); end
                endcase
            end
        end
        else begin
            q.month = (pick == 15) ? MONTH_W'($urandom_range(0, 15))
                                   : MONTH_W'($urandom_range(1, 12));
            case ($urandom_range(0, 15))
                0, 1, 2:    q.day = DAY_W'($urandom_range(28, 31));
                3:          q.day = DAY_W'($urandom_range(0, 31));
                default:    q.day = DAY_W'($urandom_range(1, 29));
            endcase
        end
        return q;
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: pop the next date after its idle gap, hold while stalled
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        date_req_t q;
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            send_wait  <= 0;
            send_burst <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                converted_dates.push_back(convert_date(make_date(s_tuser,
                    int'(s_tdata[13:0]), int'(s_tdata[17:14]), int'(s_tdata[22:18]))));
                if (s_tuser == DIR_P2G)
                    sent_p2g <= sent_p2g + 1;
                else
                    sent_g2p <= sent_g2p + 1;
            end
            if (s_tvalid && !s_tready) begin
                // hold the word until it is taken
            end
            else if (send_wait > 0) begin
                send_wait <= send_wait - 1;
                s_tvalid  <= 1'b0;
            end
            else if (pending_dates.size() > 0) begin
                q = pending_dates.pop_front();
                s_tvalid  <= 1'b1;
                s_tuser   <= q.dir;
                s_tdata   <= {1'b0, q.day, q.month, q.year};
                send_wait <= draw_wait(send_burst);
                if ($urandom_range(0, 63) == 0)
                    send_burst <= ~send_burst;
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each word with the oldest conversion, then
    // stall for a random number of cycles
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        date_res_t want;
        date_res_t got;
        int        n;
        if (!rst_n) begin
            m_tready   <= 1'b0;
            recv_wait  <= 0;
            recv_burst <= 1'b0;
        end
        else begin
            n = (recv_wait > 0) ? recv_wait - 1 : 0;
            if (m_tvalid && m_tready) begin
                got = '{year: m_tdata[13:0], month: m_tdata[17:14], day: m_tdata[22:18],
                        bad: m_tuser};
                seen_words <= seen_words + 1;
                if (m_tuser)
                    seen_bad <= seen_bad + 1;
                if (converted_dates.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("[%0t] unexpected word: year %0d month %0d day %0d bad %0b",
                                 $realtime, got.year, got.month, got.day, got.bad);
                end
                else begin
                    want = converted_dates.pop_front();
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.bad !== want.bad) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < MAX_REPORTS)
                            $display("[%0t] mismatch: expected %0d-%0d-%0d bad %0b,",
                                     $realtime, want.year, want.month, want.day, want.bad,
                                     " got %0d-%0d-%0d bad %0b",
                                     got.year, got.month, got.day, got.bad);
                    end
                end
                n = draw_wait(recv_burst);
                if ($urandom_range(0, 63) == 0)
                    recv_burst <= ~recv_burst;
            end
            recv_wait <= n;
            m_tready  <= (n == 0);
        end
    end

    // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        // Directed: seams, leap days, field extremes, bad months, day zero
        pending_dates.push_back(make_date(DIR_G2P, 2024, 3, 20));   // Nowruz, leap year
        pending_dates.push_back(make_date(DIR_G2P, 2024, 3, 19));
        pending_dates.push_back(make_date(DIR_G2P, 2023, 3, 21));
        pending_dates.push_back(make_date(DIR_G2P, 2000, 2, 29));
        pending_dates.push_back(make_date(DIR_G2P, 2100, 2, 29));   // century, not leap
        pending_dates.push_back(make_date(DIR_G2P, 2024, 3, 0));    // day zero
        pending_dates.push_back(make_date(DIR_G2P, 2023, 2, 31));   // past month end
        pending_dates.push_back(make_date(DIR_G2P, 1, 1, 1));
        pending_dates.push_back(make_date(DIR_G2P, 9999, 12, 31));
        pending_dates.push_back(make_date(DIR_G2P, 0, 0, 0));       // all fields zero
        pending_dates.push_back(make_date(DIR_G2P, 16383, 15, 31)); // all fields ones
        pending_dates.push_back(make_date(DIR_G2P, 2024, 13, 5));
        pending_dates.push_back(make_date(DIR_P2G, 1403, 1, 1));
        pending_dates.push_back(make_date(DIR_P2G, 1402, 12, 29));
        pending_dates.push_back(make_date(DIR_P2G, 1403, 12, 30));  // Esfand 30 in a common year by the 128-year rule
        pending_dates.push_back(make_date(DIR_P2G, 1402, 12, 30));
        pending_dates.push_back(make_date(DIR_P2G, 1402, 10, 10));  // Dey 10/11 seam
        pending_dates.push_back(make_date(DIR_P2G, 1402, 10, 11));
        pending_dates.push_back(make_date(DIR_P2G, 1403, 10, 12));
        pending_dates.push_back(make_date(DIR_P2G, 1403, 1, 0));
        pending_dates.push_back(make_date(DIR_P2G, 1, 1, 1));
        pending_dates.push_back(make_date(DIR_P2G, 9999, 12, 31));
        pending_dates.push_back(make_date(DIR_P2G, 16383, 15, 31)); // year wraps
        pending_dates.push_back(make_date(DIR_P2G, 0, 0, 0));
        pending_dates.push_back(make_date(DIR_P2G, 1400, 14, 1));

        for (int i = 0; i < N_RANDOM; i++)
            pending_dates.push_back(random_date());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Advance until every request is taken and every result is back
        while (pending_dates.size() > 0 || s_tvalid || converted_dates.size() > 0)
            @(posedge clk);
        repeat (DRAIN_EDGES) @(posedge clk);

        $display("Converted %0d Gregorian->Persian and %0d Persian->Gregorian dates,",
                 sent_g2p, sent_p2g);
        $display("%0d result words seen, %0d flagged as unplaceable, %0d mismatches",
                 seen_words, seen_bad, mismatches);
        if (mismatches == 0 && converted_dates.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* persian_gregorian_date_converter.f */
+incdir+sv
sv/pgdc_pkg.sv
sv/pgdc_month_find.sv
sv/persian_gregorian_date_converter.sv
dv/tb_top.sv
